@@ design/xor_fec_frame_release_macros.svh @@
// ---------------------------------------------------------------------------
// XOR FEC frame release assertion macros
// Shorthand for the concurrent checks used in the release sequencer.
// ---------------------------------------------------------------------------
`ifndef XOR_FEC_FRAME_RELEASE_MACROS_SVH
`define XOR_FEC_FRAME_RELEASE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define XFFR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define XFFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/xffr_pkg.sv @@
// ---------------------------------------------------------------------------
// XOR FEC frame release package
// Sizes, transaction payload types and sequencer states of the release block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package xffr_pkg;

    localparam int SLOT_BITS   = 16;
    localparam int SLOT_COUNT  = 1 << SLOT_BITS;
    localparam int CLEAR_AHEAD = 1000;
    localparam int SCAN_BACK   = 20;
    localparam int SEQ_W       = 32;
    localparam int LOW_W       = 8;
    localparam int SLOT_FIELD_W = 16;
    // Index over the scan window, which includes two leading partner entries.
    localparam int K_BITS      = $clog2(SCAN_BACK + 3);

    typedef logic [SLOT_BITS-1:0] slot_t;
    typedef logic [SEQ_W-1:0]     seq_t;
    typedef logic [K_BITS-1:0]    kidx_t;

    typedef struct packed {
        logic [LOW_W-1:0] seq_low;
        logic             parity_attached;
    } hdr_t;

    typedef struct packed {
        seq_t                    play_seq;
        logic                    recovered;
        logic [SLOT_FIELD_W-1:0] parity_slot;
        logic [SLOT_FIELD_W-1:0] partner_slot;
        logic                    last;
    } frame_t;

    typedef struct packed {
        logic parity;
        logic played;
    } map_word_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WIPE,
        ST_ARRIVE,
        ST_PRIME,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    function automatic slot_t slot_of(input seq_t s);
        return s[SLOT_BITS-1:0];
    endfunction

endpackage

@@ design/xor_fec_frame_release.sv @@
// ---------------------------------------------------------------------------
// XOR FEC frame release
// Release sequencer for an XOR-parity protected frame stream.
// ---------------------------------------------------------------------------
// After reset the block runs a clearing pass over all SLOT_COUNT (65536) slots
// of the slot memory and accepts no header transaction until it ends. Each
// header then runs a window scan, where span is the scan length (at most
// SCAN_BACK), and may wait for the frame side to take results. The scan is
// bound by the single read port of the slot memory: it reads one slot per
// cycle unless stalled by the frame side, and the neighbors of the slot being
// examined are carried in two registers, so releases written back never need
// a second read. One result is held back in a pending register so that the
// final release of a header can carry the last flag; an output register
// separates the frame side, and the block keeps scanning while a finished
// result waits there unless a further release must pass the pending one on.
`timescale 1ns / 1ps

`include "xor_fec_frame_release_macros.svh"

module xor_fec_frame_release (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           hdr_valid,
    output logic           hdr_ready,
    input  xffr_pkg::hdr_t hdr,
    output logic           frame_valid,
    input  logic           frame_ready,
    output xffr_pkg::frame_t frame
);
    import xffr_pkg::*;

    // Slot memory: one played bit and one parity bit per slot.
    map_word_t map_mem [SLOT_COUNT];
    map_word_t rd_word_reg;
    slot_t     rd_slot;
    logic      mem_we;
    slot_t     mem_waddr;
    map_word_t mem_wdata;

    state_t    state_reg, state_next;
    slot_t     clr_cnt_reg, clr_cnt_next;
    seq_t      highest_reg, highest_next;
    logic      started_reg, started_next;
    seq_t      seq_reg, seq_next;
    logic      par_reg, par_next;
    seq_t      ptr_reg, ptr_next;
    seq_t      cur_reg, cur_next;
    kidx_t     k_reg, k_next;
    kidx_t     last_k_reg, last_k_next;
    map_word_t win1_reg, win1_next;
    map_word_t win2_reg, win2_next;
    logic      pend_valid_reg, pend_valid_next;
    frame_t    pend_reg, pend_next;
    logic      out_valid_reg, out_valid_next;
    frame_t    out_reg, out_next;

    // Scan step evaluation.
    logic      out_free;
    logic      do_eval;
    logic      rel1;
    logic      rel2;
    logic      stall;
    frame_t    new_frame;
    logic [LOW_W-1:0] diff;
    seq_t      wide_seq;
    seq_t      scan_start;
    kidx_t     span;

    assign hdr_ready   = (state_reg == ST_IDLE);
    assign frame_valid = out_valid_reg;
    assign frame       = out_reg;

    // The output register can take a new result when it is empty or being taken.
    assign out_free = !out_valid_reg || frame_ready;

    // Widening of the 8-bit sequence: the low-byte difference, read as a signed
    // byte, is the offset from the highest sequence seen.
    assign diff     = hdr.seq_low - highest_reg[LOW_W-1:0];
    assign wide_seq = highest_reg + {{(SEQ_W-LOW_W){diff[LOW_W-1]}}, diff};

    assign scan_start = (highest_reg > SEQ_W'(SCAN_BACK))
                        ? highest_reg - SEQ_W'(SCAN_BACK) : '0;
    assign span       = (highest_reg > SEQ_W'(SCAN_BACK))
                        ? K_BITS'(SCAN_BACK) : highest_reg[K_BITS-1:0];

    // A slot holding parity with exactly one played predecessor releases the
    // other one. The first two window entries only load the neighbor registers.
    assign do_eval = (state_reg == ST_SCAN) && (k_reg >= K_BITS'(2))
                     && (cur_reg >= SEQ_W'(2)) && rd_word_reg.parity;
    assign rel1    = do_eval && !win1_reg.played && win2_reg.played;
    assign rel2    = do_eval && !rel1 && !win2_reg.played && win1_reg.played;
    assign stall   = (rel1 || rel2) && pend_valid_reg && !out_free;

    always_comb
    begin
        new_frame              = '0;
        new_frame.recovered    = 1'b1;
        new_frame.parity_slot  = SLOT_FIELD_W'(slot_of(cur_reg));
        if (rel1)
        begin
            new_frame.play_seq     = cur_reg - SEQ_W'(1);
            new_frame.partner_slot = SLOT_FIELD_W'(slot_of(cur_reg - SEQ_W'(2)));
        end
        else
        begin
            new_frame.play_seq     = cur_reg - SEQ_W'(2);
            new_frame.partner_slot = SLOT_FIELD_W'(slot_of(cur_reg - SEQ_W'(1)));
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            map_mem[mem_waddr] <= mem_wdata;
        end
        rd_word_reg <= map_mem[rd_slot];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            highest_reg    <= '0;
            started_reg    <= 1'b0;
            k_reg          <= '0;
            last_k_reg     <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            highest_reg    <= highest_next;
            started_reg    <= started_next;
            k_reg          <= k_next;
            last_k_reg     <= last_k_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seq_reg  <= seq_next;
        par_reg  <= par_next;
        ptr_reg  <= ptr_next;
        cur_reg  <= cur_next;
        win1_reg <= win1_next;
        win2_reg <= win2_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        highest_next    = highest_reg;
        started_next    = started_reg;
        seq_next        = seq_reg;
        par_next        = par_reg;
        ptr_next        = ptr_reg;
        cur_next        = cur_reg;
        k_next          = k_reg;
        last_k_next     = last_k_reg;
        win1_next       = win1_reg;
        win2_next       = win2_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        mem_we          = 1'b0;
        mem_waddr       = slot_of(ptr_reg);
        mem_wdata       = '0;
        rd_slot         = slot_of(ptr_reg);

        if (out_valid_reg && frame_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + SLOT_BITS'(1);
                if (clr_cnt_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (hdr_valid)
                begin
                    par_next     = hdr.parity_attached;
                    started_next = 1'b1;
                    if (!started_reg)
                    begin
                        seq_next     = SEQ_W'(hdr.seq_low);
                        highest_next = SEQ_W'(hdr.seq_low);
                    end
                    else
                    begin
                        seq_next = wide_seq;
                        if (wide_seq > highest_reg)
                        begin
                            highest_next = wide_seq;
                        end
                    end
                    state_next = ST_WIPE;
                end
            end
            ST_WIPE:
            begin
                // Clear both marks well ahead, and fetch the arriving slot.
                mem_we     = 1'b1;
                mem_waddr  = slot_of(seq_reg) + SLOT_BITS'(CLEAR_AHEAD);
                rd_slot    = slot_of(seq_reg);
                state_next = ST_ARRIVE;
            end
            ST_ARRIVE:
            begin
                mem_we           = 1'b1;
                mem_waddr        = slot_of(seq_reg);
                mem_wdata.played = 1'b1;
                mem_wdata.parity = par_reg || rd_word_reg.parity;
                if (!rd_word_reg.played)
                begin
                    pend_valid_next = 1'b1;
                    pend_next       = '0;
                    pend_next.play_seq = seq_reg;
                end
                ptr_next    = scan_start - SEQ_W'(2);
                last_k_next = span + K_BITS'(2);
                state_next  = ST_PRIME;
            end
            ST_PRIME:
            begin
                rd_slot    = slot_of(ptr_reg);
                ptr_next   = ptr_reg + SEQ_W'(1);
                cur_next   = ptr_reg;
                k_next     = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (stall)
                begin
                    // Hold the current slot's read data while the frame side waits.
                    rd_slot = slot_of(cur_reg);
                end
                else
                begin
                    rd_slot  = slot_of(ptr_reg);
                    ptr_next = ptr_reg + SEQ_W'(1);
                    cur_next = ptr_reg;
                    k_next   = k_reg + K_BITS'(1);
                    win1_next = rd_word_reg;
                    win2_next = win1_reg;
                    if (rel1 || rel2)
                    begin
                        mem_we           = 1'b1;
                        mem_wdata.played = 1'b1;
                        if (rel1)
                        begin
                            mem_waddr        = slot_of(cur_reg - SEQ_W'(1));
                            mem_wdata.parity = win1_reg.parity;
                            win2_next.played = 1'b1;
                        end
                        else
                        begin
                            mem_waddr        = slot_of(cur_reg - SEQ_W'(2));
                            mem_wdata.parity = win2_reg.parity;
                        end
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_next       = pend_reg;
                        end
                        pend_valid_next = 1'b1;
                        pend_next       = new_frame;
                    end
                    if (k_reg == last_k_reg)
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_next        = pend_reg;
                    out_next.last   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `XFFR_ASSERT_NEXT(a_accept_starts_wipe, hdr_valid && hdr_ready, state_reg == ST_WIPE, "accepted header did not start the clear-ahead step")
    `XFFR_ASSERT_NOW(a_idle_no_pending, hdr_ready, !pend_valid_reg, "header accepted while a result of the previous header is still pending")
    `XFFR_ASSERT_NEXT(a_highest_monotonic, started_reg, highest_reg >= $past(highest_reg), "highest sequence moved backward")
    `XFFR_ASSERT_NOW(a_scan_in_window, state_reg == ST_SCAN, k_reg <= last_k_reg, "scan index ran past the window end")

endmodule
